FILE: rtl/core/touch_slide_gesture_detector_top_macros.svh
// assertion helpers for the slide detector
`ifndef TOUCH_SLIDE_GESTURE_DETECTOR_TOP_MACROS_SVH
`define TOUCH_SLIDE_GESTURE_DETECTOR_TOP_MACROS_SVH

// checked on every edge out of reset
`define TSGD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same, with a fixed message
`define TSGD_CHECK(label, prop) \
	`TSGD_ASSERT(label, prop, "tsgd sequencer check failed")

`endif

FILE: rtl/core/tsgd_pkg.sv
`timescale 1ns / 1ps
package tsgd_pkg;
	localparam int PadCount = 3;

	localparam logic [2:0] REG_DEBOUNCE  = 3'd0;
	localparam logic [2:0] REG_TIMEOUT   = 3'd1;
	localparam logic [2:0] REG_HOLD_MIN  = 3'd2;
	localparam logic [2:0] REG_HOLD_MAX  = 3'd3;
	localparam logic [2:0] REG_SPEED_MIN = 3'd4;
	localparam logic [2:0] REG_SPEED_MAX = 3'd5;
	localparam logic [2:0] REG_SPACING   = 3'd6;
	localparam logic [2:0] REG_JUMP      = 3'd7;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_REJECT = 2'd1;
	localparam logic [1:0] EV_FWD    = 2'd2;
	localparam logic [1:0] EV_BWD    = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FIRST,
		PH_SECOND,
		PH_FINISH
	} ph_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HOLD,
		ST_DIV_A,
		ST_WAIT_A,
		ST_DIV_B,
		ST_WAIT_B,
		ST_EMIT
	} st_t;
endpackage

FILE: rtl/core/tsgd_if.sv
`timescale 1ns / 1ps
interface tsgd_pad_if;
	logic       valid;
	logic       ready;
	logic [2:0] pad_levels;
	modport source (output valid, output pad_levels, input ready);
	modport sink (input valid, input pad_levels, output ready);
endinterface

interface tsgd_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_code;
	logic       lone_pad_valid;
	logic [1:0] lone_pad_index;
	modport source (output valid, output event_code, output lone_pad_valid,
		output lone_pad_index, input ready);
	modport sink (input valid, input event_code, input lone_pad_valid,
		input lone_pad_index, output ready);
endinterface

FILE: rtl/core/tsgd_div.sv
`timescale 1ns / 1ps
module tsgd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [15:0] quotient
);
	logic [16:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] div_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [16:0] shifted;
	logic        fits;

	assign shifted  = {rem_q[15:0], quo_q[15]};
	assign fits     = shifted >= {1'b0, div_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 5'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 5'd16;
			end else if (cnt_q != 5'd0) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1)
					done_q <= 1'b1;
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 17'd0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != 5'd0) begin
			rem_q <= fits ? shifted - {1'b0, div_q} : shifted;
			quo_q <= {quo_q[14:0], fits};
		end
	end
endmodule

FILE: rtl/core/touch_slide_gesture_detector_top.sv
`timescale 1ns / 1ps
// Three-pad slide detector, one input beat per scan tick and one result beat per tick.
// A tick that does not finish a slide goes through debounce and tracking in the accept
// cycle, then the result register. A tick that finishes a slide goes through the accept cycle,
// a hold-time check, two serial divisions (each a start, sixteen quotient bits and a done
// flag) for the neighbour velocities on the one shared divider, then the result register;
// a failed check skips the steps after it. A stalled result beat holds the block in its
// result cycle. No new tick is taken meanwhile.
`include "touch_slide_gesture_detector_top_macros.svh"
module touch_slide_gesture_detector_top (
	input  logic        clk,
	input  logic        arst_n,
	tsgd_pad_if.sink    pad_in,
	tsgd_evt_if.source  evt_out,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	logic [15:0] debounce_q;
	logic [7:0]  timeout_q;
	logic [23:0] hold_min_q, hold_max_q, jump_q;
	logic [15:0] speed_min_q, speed_max_q;
	logic [31:0] spacing_q;

	logic [7:0]  pc_q [tsgd_pkg::PadCount];
	logic [7:0]  rc_q [tsgd_pkg::PadCount];
	logic [15:0] ps_q [tsgd_pkg::PadCount];
	logic [15:0] rs_q [tsgd_pkg::PadCount];
	logic [7:0]  pc_n [tsgd_pkg::PadCount];
	logic [7:0]  rc_n [tsgd_pkg::PadCount];
	logic [15:0] ps_n [tsgd_pkg::PadCount];
	logic [15:0] rs_n [tsgd_pkg::PadCount];
	tsgd_pkg::ph_t phase_q, phase_n;
	logic [1:0]  latest_q, latest_n, start_q, start_n;
	logic [15:0] tick_q, tick_n;

	tsgd_pkg::st_t state_q, state_n;
	logic [1:0]  ev_q, ev_n;
	logic        lone_v_q, lone_v_n;
	logic [1:0]  lone_i_q, lone_i_n;
	logic        judge;
	logic [15:0] last_q;

	logic        out_valid_q;
	logic [1:0]  out_ev_q;
	logic        out_lv_q;
	logic [1:0]  out_li_q;

	logic        accept;
	logic [7:0]  press_lim, rel_lim;
	logic [1:0]  touched;
	logic [1:0]  idx;
	logic [16:0] since_raw;
	logic [16:0] since;

	logic        hold_bad;
	logic [15:0] hold [tsgd_pkg::PadCount];
	logic        fwd;
	logic        gap_sel;
	logic [15:0] gap;
	logic [15:0] spacing;
	logic        div_start, div_done;
	logic [15:0] velo;
	logic [15:0] jump_d;
	logic        velo_bad;
	logic        emit_go;

	assign accept    = pad_in.valid & pad_in.ready;
	assign press_lim = debounce_q[7:0];
	assign rel_lim   = debounce_q[15:8];
	assign fwd       = (start_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= 16'd771;
			timeout_q   <= 8'd100;
			hold_min_q  <= 24'd0;
			hold_max_q  <= 24'hffffff;
			speed_min_q <= 16'd0;
			speed_max_q <= 16'hffff;
			spacing_q   <= 32'd6553700;
			jump_q      <= 24'hffff;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsgd_pkg::REG_DEBOUNCE:  debounce_q  <= cfg_wdata[15:0];
				tsgd_pkg::REG_TIMEOUT:   timeout_q   <= cfg_wdata[7:0];
				tsgd_pkg::REG_HOLD_MIN:  hold_min_q  <= cfg_wdata[23:0];
				tsgd_pkg::REG_HOLD_MAX:  hold_max_q  <= cfg_wdata[23:0];
				tsgd_pkg::REG_SPEED_MIN: speed_min_q <= cfg_wdata[15:0];
				tsgd_pkg::REG_SPEED_MAX: speed_max_q <= cfg_wdata[15:0];
				tsgd_pkg::REG_SPACING:   spacing_q   <= cfg_wdata;
				tsgd_pkg::REG_JUMP:      jump_q      <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	// debounce and gesture tracking for the accepted tick
	always_comb begin
		tick_n  = tick_q + 16'd1;
		touched = 2'd0;
		idx     = 2'd0;
		for (int p = 0; p < tsgd_pkg::PadCount; p++) begin
			pc_n[p] = pc_q[p];
			rc_n[p] = rc_q[p];
			ps_n[p] = ps_q[p];
			rs_n[p] = rs_q[p];
			if (!pad_in.pad_levels[p]) begin
				touched = touched + 2'd1;
				idx     = 2'(p);
				if (pc_q[p] < press_lim) begin
					pc_n[p] = pc_q[p] + 8'd1;
					if (pc_n[p] == press_lim) begin
						ps_n[p] = tick_n;
						rc_n[p] = 8'd0;
					end
				end else begin
					rc_n[p] = 8'd0;
				end
			end else begin
				if (rc_q[p] < rel_lim) begin
					rc_n[p] = rc_q[p] + 8'd1;
					if (rc_n[p] == rel_lim)
						rs_n[p] = tick_n;
				end else begin
					pc_n[p] = 8'd0;
				end
			end
		end

		lone_v_n = 1'b0;
		lone_i_n = 2'd0;
		if (touched <= 2'd1 && (phase_q == tsgd_pkg::PH_IDLE
				|| phase_q == tsgd_pkg::PH_FIRST)) begin
			ev_n = tsgd_pkg::EV_NONE;
			if (touched == 2'd1) begin
				lone_v_n = 1'b1;
				lone_i_n = idx;
			end
		end else begin
			ev_n = tsgd_pkg::EV_REJECT;
		end

		phase_n  = phase_q;
		latest_n = latest_q;
		start_n  = start_q;
		unique case (phase_q)
			tsgd_pkg::PH_IDLE: begin
				if (touched == 2'd1 && (idx == 2'd0 || idx == 2'd2)
						&& pc_n[idx] == press_lim) begin
					phase_n  = tsgd_pkg::PH_FIRST;
					start_n  = idx;
					latest_n = idx;
				end
			end
			tsgd_pkg::PH_FIRST: begin
				if (touched == 2'd1 && idx != latest_q && pc_n[idx] == press_lim) begin
					phase_n  = tsgd_pkg::PH_SECOND;
					latest_n = idx;
				end
			end
			tsgd_pkg::PH_SECOND: begin
				if (touched == 2'd1 && pc_n[idx] == press_lim) begin
					latest_n = idx;
					if ((idx == 2'd0 || idx == 2'd2) && idx != start_q)
						phase_n = tsgd_pkg::PH_FINISH;
				end
			end
			default: ;
		endcase

		judge = 1'b0;
		if (phase_n == tsgd_pkg::PH_FINISH && rc_n[latest_n] == rel_lim) begin
			judge    = 1'b1;
			lone_v_n = 1'b0;
			lone_i_n = 2'd0;
			phase_n  = tsgd_pkg::PH_IDLE;
		end

		// tick distance modulo 0xffff
		since_raw = {1'b0, tick_n} + 17'd65535 - {1'b0, rs_n[latest_n]};
		if (since_raw >= 17'd131070)
			since = since_raw - 17'd131070;
		else if (since_raw >= 17'd65535)
			since = since_raw - 17'd65535;
		else
			since = since_raw;
		if (phase_n != tsgd_pkg::PH_IDLE && rc_n[latest_n] == rel_lim
				&& since > {9'd0, timeout_q})
			phase_n = tsgd_pkg::PH_IDLE;
	end

	// slide judging datapath
	always_comb begin
		hold_bad = 1'b0;
		for (int n = 0; n < tsgd_pkg::PadCount; n++) begin
			hold[n] = (rs_q[n] > ps_q[n]) ? rs_q[n] - ps_q[n] : ps_q[n] - rs_q[n];
			if (hold[n] < {8'd0, hold_min_q[8*n +: 8]}
					|| hold[n] > {8'd0, hold_max_q[8*n +: 8]})
				hold_bad = 1'b1;
		end
		gap_sel = (state_q == tsgd_pkg::ST_DIV_A || state_q == tsgd_pkg::ST_WAIT_A)
			? !fwd : fwd;
		if (gap_sel)
			gap = (rs_q[2] > rs_q[1]) ? rs_q[2] - rs_q[1] : rs_q[1] - rs_q[2];
		else
			gap = (rs_q[1] > rs_q[0]) ? rs_q[1] - rs_q[0] : rs_q[0] - rs_q[1];
		spacing   = gap_sel ? spacing_q[31:16] : spacing_q[15:0];
		div_start = (state_q == tsgd_pkg::ST_DIV_A || state_q == tsgd_pkg::ST_DIV_B)
			&& gap != 16'd0;
		jump_d    = (velo > last_q) ? velo - last_q : last_q - velo;
		velo_bad  = velo < {8'd0, speed_min_q[8*gap_sel +: 8]}
			|| velo > {8'd0, speed_max_q[8*gap_sel +: 8]}
			|| (last_q != 16'd0 && jump_d > {8'd0, jump_q[7:0]});
		emit_go   = !out_valid_q || evt_out.ready;
	end

	tsgd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (spacing),
		.divisor  (gap),
		.done     (div_done),
		.quotient (velo)
	);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			tsgd_pkg::ST_IDLE:
				if (accept)
					state_n = judge ? tsgd_pkg::ST_HOLD : tsgd_pkg::ST_EMIT;
			tsgd_pkg::ST_HOLD:
				state_n = hold_bad ? tsgd_pkg::ST_EMIT : tsgd_pkg::ST_DIV_A;
			tsgd_pkg::ST_DIV_A:
				state_n = (gap == 16'd0) ? tsgd_pkg::ST_EMIT : tsgd_pkg::ST_WAIT_A;
			tsgd_pkg::ST_WAIT_A:
				if (div_done)
					state_n = velo_bad ? tsgd_pkg::ST_EMIT : tsgd_pkg::ST_DIV_B;
			tsgd_pkg::ST_DIV_B:
				state_n = (gap == 16'd0) ? tsgd_pkg::ST_EMIT : tsgd_pkg::ST_WAIT_B;
			tsgd_pkg::ST_WAIT_B:
				if (div_done)
					state_n = tsgd_pkg::ST_EMIT;
			tsgd_pkg::ST_EMIT:
				if (emit_go)
					state_n = tsgd_pkg::ST_IDLE;
			default: state_n = tsgd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pad_in.ready          = (state_q == tsgd_pkg::ST_IDLE);
		evt_out.valid         = out_valid_q;
		evt_out.event_code    = out_ev_q;
		evt_out.lone_pad_valid = out_lv_q;
		evt_out.lone_pad_index = out_li_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tsgd_pkg::ST_IDLE;
			phase_q  <= tsgd_pkg::PH_IDLE;
			latest_q <= 2'd0;
			start_q  <= 2'd0;
			tick_q   <= 16'd0;
			for (int p = 0; p < tsgd_pkg::PadCount; p++) begin
				pc_q[p] <= 8'd0;
				rc_q[p] <= 8'd0;
				ps_q[p] <= 16'd0;
				rs_q[p] <= 16'd0;
			end
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept) begin
				phase_q  <= phase_n;
				latest_q <= latest_n;
				start_q  <= start_n;
				tick_q   <= tick_n;
				for (int p = 0; p < tsgd_pkg::PadCount; p++) begin
					pc_q[p] <= pc_n[p];
					rc_q[p] <= rc_n[p];
					ps_q[p] <= ps_n[p];
					rs_q[p] <= rs_n[p];
				end
			end
			if (state_q == tsgd_pkg::ST_EMIT && emit_go)
				out_valid_q <= 1'b1;
			else if (evt_out.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q) inside
			tsgd_pkg::ST_IDLE:
				if (accept) begin
					ev_q     <= ev_n;
					lone_v_q <= lone_v_n;
					lone_i_q <= lone_i_n;
					last_q   <= 16'd0;
				end
			tsgd_pkg::ST_HOLD:
				ev_q <= tsgd_pkg::EV_REJECT;
			tsgd_pkg::ST_DIV_A, tsgd_pkg::ST_DIV_B: ;
			tsgd_pkg::ST_WAIT_A, tsgd_pkg::ST_WAIT_B:
				if (div_done) begin
					last_q <= velo;
					// only one jump, so it is also the jump total
					if (state_q == tsgd_pkg::ST_WAIT_B && !velo_bad
							&& !(last_q != 16'd0 && jump_d > jump_q[23:8]))
						ev_q <= fwd ? tsgd_pkg::EV_FWD : tsgd_pkg::EV_BWD;
				end
			tsgd_pkg::ST_EMIT:
				if (emit_go) begin
					out_ev_q <= ev_q;
					out_lv_q <= lone_v_q;
					out_li_q <= lone_i_q;
				end
			default: ;
		endcase
	end

	`TSGD_ASSERT(a_busy_after_beat, accept |=> !pad_in.ready, "tick taken while busy")
	`TSGD_CHECK(a_div_in_wait, div_done |-> (state_q == tsgd_pkg::ST_WAIT_A
		|| state_q == tsgd_pkg::ST_WAIT_B))
	`TSGD_CHECK(a_judge_resets, state_q == tsgd_pkg::ST_HOLD |-> phase_q == tsgd_pkg::PH_IDLE)
	`TSGD_ASSERT(a_emit_loads, (state_q == tsgd_pkg::ST_EMIT && emit_go) |=> out_valid_q,
		"result beat lost")
endmodule

FILE: test/touch_slide_gesture_detector_top_tb.sv
`timescale 1ns / 1ps
module touch_slide_gesture_detector_top_tb;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [1:0] ev;
		logic       lone_valid;
		logic [1:0] lone_idx;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_wdata;

	tsgd_pad_if pad_ch ();
	tsgd_evt_if evt_ch ();

	touch_slide_gesture_detector_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pad_in   (pad_ch.sink),
		.evt_out  (evt_ch.source),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow configuration
	logic [15:0] debounce_cfg;
	logic [7:0]  timeout_cfg;
	logic [23:0] hold_min_cfg, hold_max_cfg, jump_cfg;
	logic [15:0] speed_min_cfg, speed_max_cfg;
	logic [31:0] spacing_cfg;

	// shadow tracker state
	logic [7:0]  press_cnt [tsgd_pkg::PadCount];
	logic [7:0]  release_cnt [tsgd_pkg::PadCount];
	logic [15:0] press_tick [tsgd_pkg::PadCount];
	logic [15:0] rel_stamp [tsgd_pkg::PadCount];
	tsgd_pkg::ph_t phase;
	logic [1:0]  latest_pad, start_pad;
	logic [15:0] tick_now;

	tick_result_t expected_events[$];
	int ticks_sent = 0, events_seen = 0, errors = 0;
	int fwd_slides = 0, bwd_slides = 0, rejected = 0, lone_seen = 0;
	int cycles = 0;

	function automatic int unsigned tick_dist(logic [15:0] a, logic [15:0] b);
		return (a > b) ? int'(a - b) : int'(b - a);
	endfunction

	function automatic logic [1:0] judge_slide();
		logic        fwd;
		int unsigned last, total, hold, gap, v, d, g;
		fwd = (start_pad == 2'd0);
		last = 0;
		total = 0;
		for (int n = 0; n < tsgd_pkg::PadCount; n++) begin
			hold = tick_dist(rel_stamp[n], press_tick[n]);
			if (hold < hold_min_cfg[8*n +: 8] || hold > hold_max_cfg[8*n +: 8])
				return tsgd_pkg::EV_REJECT;
		end
		for (int n = 0; n < tsgd_pkg::PadCount - 1; n++) begin
			g = fwd ? n : (tsgd_pkg::PadCount - 2 - n);
			gap = tick_dist(rel_stamp[g + 1], rel_stamp[g]);
			if (gap == 0)
				return tsgd_pkg::EV_REJECT;
			v = spacing_cfg[16*g +: 16] / gap;
			if (v < speed_min_cfg[8*g +: 8] || v > speed_max_cfg[8*g +: 8])
				return tsgd_pkg::EV_REJECT;
			if (last != 0) begin
				d = (v > last) ? v - last : last - v;
				if (d > jump_cfg[7:0])
					return tsgd_pkg::EV_REJECT;
				total += d;
			end
			last = v;
		end
		if (total > jump_cfg[23:8])
			return tsgd_pkg::EV_REJECT;
		return fwd ? tsgd_pkg::EV_FWD : tsgd_pkg::EV_BWD;
	endfunction

	function automatic tick_result_t scan_tick(logic [2:0] levels);
		tick_result_t r;
		logic [7:0]   press_lim, rel_lim;
		int           touched, idx;
		int unsigned  since;
		press_lim = debounce_cfg[7:0];
		rel_lim = debounce_cfg[15:8];
		touched = 0;
		idx = 0;
		r = '0;
		tick_now = tick_now + 16'd1;
		for (int p = 0; p < tsgd_pkg::PadCount; p++) begin
			if (!levels[p]) begin
				touched++;
				idx = p;
				if (press_cnt[p] < press_lim) begin
					press_cnt[p]++;
					if (press_cnt[p] == press_lim) begin
						press_tick[p] = tick_now;
						release_cnt[p] = '0;
					end
				end else begin
					release_cnt[p] = '0;
				end
			end else begin
				if (release_cnt[p] < rel_lim) begin
					release_cnt[p]++;
					if (release_cnt[p] == rel_lim)
						rel_stamp[p] = tick_now;
				end else begin
					press_cnt[p] = '0;
				end
			end
		end
		if (touched <= 1 && (phase == tsgd_pkg::PH_IDLE || phase == tsgd_pkg::PH_FIRST)) begin
			r.ev = tsgd_pkg::EV_NONE;
			if (touched == 1) begin
				r.lone_valid = 1'b1;
				r.lone_idx = idx[1:0];
			end
		end else begin
			r.ev = tsgd_pkg::EV_REJECT;
		end
		case (phase)
			tsgd_pkg::PH_IDLE: begin
				if (touched == 1 && (idx == 0 || idx == tsgd_pkg::PadCount - 1) &&
						press_cnt[idx] == press_lim) begin
					phase = tsgd_pkg::PH_FIRST;
					start_pad = idx[1:0];
					latest_pad = idx[1:0];
				end
			end
			tsgd_pkg::PH_FIRST: begin
				if (touched == 1 && idx != latest_pad && press_cnt[idx] == press_lim) begin
					phase = tsgd_pkg::PH_SECOND;
					latest_pad = idx[1:0];
				end
			end
			tsgd_pkg::PH_SECOND: begin
				if (touched == 1 && press_cnt[idx] == press_lim) begin
					latest_pad = idx[1:0];
					if ((idx == 0 || idx == tsgd_pkg::PadCount - 1) && idx != start_pad)
						phase = tsgd_pkg::PH_FINISH;
				end
			end
			default: ;
		endcase
		if (latest_pad >= tsgd_pkg::PadCount)
			latest_pad = '0;
		if (phase == tsgd_pkg::PH_FINISH && release_cnt[latest_pad] == rel_lim) begin
			r.ev = judge_slide();
			r.lone_valid = 1'b0;
			r.lone_idx = '0;
			phase = tsgd_pkg::PH_IDLE;
		end
		if (phase != tsgd_pkg::PH_IDLE && release_cnt[latest_pad] == rel_lim) begin
			since = (32'(tick_now) + 32'hffff - 32'(rel_stamp[latest_pad])) % 32'hffff;
			if (since > timeout_cfg)
				phase = tsgd_pkg::PH_IDLE;
		end
		return r;
	endfunction

	// sender: bursts of random length with random gaps
	int burst_left = 0;

	task automatic send_tick(input logic [2:0] levels);
		int gap;
		pad_ch.valid <= 1'b1;
		pad_ch.pad_levels <= levels;
		do @(posedge clk); while (!(pad_ch.valid && pad_ch.ready));
		expected_events.push_back(scan_tick(levels));
		ticks_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
			gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				pad_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop sending and let every result (and any slide check in flight) drain
	task automatic wait_idle();
		pad_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_events.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		case (index)
			tsgd_pkg::REG_DEBOUNCE:  debounce_cfg = value[15:0];
			tsgd_pkg::REG_TIMEOUT:   timeout_cfg = value[7:0];
			tsgd_pkg::REG_HOLD_MIN:  hold_min_cfg = value[23:0];
			tsgd_pkg::REG_HOLD_MAX:  hold_max_cfg = value[23:0];
			tsgd_pkg::REG_SPEED_MIN: speed_min_cfg = value[15:0];
			tsgd_pkg::REG_SPEED_MAX: speed_max_cfg = value[15:0];
			tsgd_pkg::REG_SPACING:   spacing_cfg = value;
			default:                 jump_cfg = value[23:0];
		endcase
	endtask

	task automatic write_all(input logic [31:0] v [8]);
		wait_idle();
		write_reg(tsgd_pkg::REG_DEBOUNCE, v[0]);
		write_reg(tsgd_pkg::REG_TIMEOUT, v[1]);
		write_reg(tsgd_pkg::REG_HOLD_MIN, v[2]);
		write_reg(tsgd_pkg::REG_HOLD_MAX, v[3]);
		write_reg(tsgd_pkg::REG_SPEED_MIN, v[4]);
		write_reg(tsgd_pkg::REG_SPEED_MAX, v[5]);
		write_reg(tsgd_pkg::REG_SPACING, v[6]);
		write_reg(tsgd_pkg::REG_JUMP, v[7]);
		cfg_we <= 1'b0;
	endtask

	task automatic hold_levels(input logic [2:0] levels, input int ticks);
		repeat (ticks) send_tick(levels);
	endtask

	// end-to-end slide with random hold lengths, overlaps and a random release tail
	task automatic random_slide(input int max_hold);
		logic fwd;
		int   pad, nxt;
		fwd = 1'($urandom_range(0, 1));
		for (int k = 0; k < tsgd_pkg::PadCount; k++) begin
			pad = fwd ? k : tsgd_pkg::PadCount - 1 - k;
			hold_levels(~(3'b001 << pad), $urandom_range(1, max_hold));
			if (k < tsgd_pkg::PadCount - 1 && $urandom_range(0, 3) == 0) begin
				nxt = fwd ? pad + 1 : pad - 1;
				hold_levels(~((3'b001 << pad) | (3'b001 << nxt)), $urandom_range(1, 3));
			end
			if ($urandom_range(0, 5) == 0)
				hold_levels(3'b111, $urandom_range(1, 4));
		end
		hold_levels(3'b111, $urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : $urandom_range(1, 8));
	endtask

	task automatic random_traffic(input int n_ticks, input int max_hold);
		int stop_at;
		stop_at = ticks_sent + n_ticks;
		while (ticks_sent < stop_at) begin
			if ($urandom_range(0, 99) < 80)
				random_slide(max_hold);
			else
				hold_levels(3'($urandom), $urandom_range(1, 6));
		end
	endtask

	task automatic random_config();
		logic [31:0] v [8];
		v[0] = (32'($urandom_range(1, 4)) << 8) | 32'($urandom_range(1, 4));
		v[1] = $urandom_range(5, 255);
		v[2] = 32'({8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
			8'($urandom_range(0, 3))});
		v[3] = 32'({8'($urandom_range(6, 255)), 8'($urandom_range(6, 255)),
			8'($urandom_range(6, 255))});
		v[4] = 32'({8'($urandom_range(0, 20)), 8'($urandom_range(0, 20))});
		v[5] = 32'({8'($urandom_range(40, 255)), 8'($urandom_range(40, 255))});
		v[6] = {16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000))};
		v[7] = 32'({16'($urandom_range(0, 400)), 8'($urandom_range(0, 255))});
		write_all(v);
	endtask

	task automatic test_directed();
		// forward and backward slides on the reset settings
		hold_levels(3'b110, 4); hold_levels(3'b101, 4); hold_levels(3'b011, 4);
		hold_levels(3'b111, 5);
		hold_levels(3'b011, 3); hold_levels(3'b101, 3); hold_levels(3'b110, 3);
		hold_levels(3'b111, 4);
		// every pad together, the two outer pads, a lone middle pad and none
		send_tick(3'b000);
		send_tick(3'b010);
		send_tick(3'b101);
		send_tick(3'b111);
	endtask

	task automatic test_config_extremes();
		logic [31:0] v [8];
		// all registers at zero: zero debounce never stamps
		v = '{default: 32'h0};
		write_all(v);
		repeat (30) send_tick(3'($urandom));
		random_traffic(20, 4);
		// all registers at their maximum: long debounce
		v = '{32'hffff, 32'hff, 32'hffffff, 32'hffffff, 32'hffff, 32'hffff,
			32'hffffffff, 32'hffffff};
		write_all(v);
		random_traffic(60, 10);
		// quick debounce and a short timeout
		v = '{32'h0101, 32'h2, 32'h0, 32'hffffff, 32'h0, 32'hffff, 32'h00640064, 32'hffffff};
		write_all(v);
		random_traffic(80, 4);
		// reset values again
		v = '{32'd771, 32'd100, 32'h0, 32'hffffff, 32'h0, 32'hffff, 32'd6553700, 32'hffff};
		write_all(v);
	endtask

	task automatic test_random();
		random_traffic(400, 8);
		for (int ph = 0; ph < 5; ph++) begin
			random_config();
			random_traffic(200, 8);
		end
	endtask

	task automatic test_pause_to_empty();
		random_traffic(30, 6);
		// nothing in flight before the next slide
		wait_idle();
		random_traffic(30, 6);
	endtask

	// receiver stall pattern: modes held for random stretches
	int rx_mode = 0, rx_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_ch.ready <= 1'b0;
			rx_mode <= 0;
			rx_left <= 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_left <= $urandom_range(10, 120);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				0: evt_ch.ready <= 1'b1;
				1: evt_ch.ready <= $urandom_range(0, 1);
				2: evt_ch.ready <= ($urandom_range(0, 3) == 0);
				default: evt_ch.ready <= (rx_left % 16) > 11;
			endcase
		end
	end

	always @(posedge clk) begin
		tick_result_t exp_r;
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			events_seen++;
			if (expected_events.size() == 0) begin
				$display("%0t: unexpected beat ev=%0d lone=%0b idx=%0d", $time,
					evt_ch.event_code, evt_ch.lone_pad_valid, evt_ch.lone_pad_index);
				errors++;
			end else begin
				exp_r = expected_events.pop_front();
				case (exp_r.ev)
					tsgd_pkg::EV_FWD: fwd_slides++;
					tsgd_pkg::EV_BWD: bwd_slides++;
					tsgd_pkg::EV_REJECT: rejected++;
					default: ;
				endcase
				if (exp_r.lone_valid)
					lone_seen++;
				if (evt_ch.event_code !== exp_r.ev)
					$display("%0t: event_code expected %0d actual %0d", $time,
						exp_r.ev, evt_ch.event_code);
				if (evt_ch.lone_pad_valid !== exp_r.lone_valid)
					$display("%0t: lone_pad_valid expected %0b actual %0b", $time,
						exp_r.lone_valid, evt_ch.lone_pad_valid);
				if (evt_ch.lone_pad_index !== exp_r.lone_idx)
					$display("%0t: lone_pad_index expected %0d actual %0d", $time,
						exp_r.lone_idx, evt_ch.lone_pad_index);
				if (evt_ch.event_code !== exp_r.ev || evt_ch.lone_pad_valid !== exp_r.lone_valid
						|| evt_ch.lone_pad_index !== exp_r.lone_idx)
					errors++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d beats outstanding", $time, expected_events.size());
			$display("touch_slide_gesture_detector_top test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		pad_ch.valid <= 1'b0;
		pad_ch.pad_levels <= 3'b111;
		cfg_we <= 1'b0;
		cfg_index <= tsgd_pkg::REG_DEBOUNCE;
		cfg_wdata <= '0;
		debounce_cfg = 16'd771;
		timeout_cfg = 8'd100;
		hold_min_cfg = '0;
		hold_max_cfg = 24'hffffff;
		speed_min_cfg = '0;
		speed_max_cfg = 16'hffff;
		spacing_cfg = 32'd6553700;
		jump_cfg = 24'h00ffff;
		for (int p = 0; p < tsgd_pkg::PadCount; p++) begin
			press_cnt[p] = '0;
			release_cnt[p] = '0;
			press_tick[p] = '0;
			rel_stamp[p] = '0;
		end
		phase = tsgd_pkg::PH_IDLE;
		latest_pad = '0;
		start_pad = '0;
		tick_now = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_extremes();
		test_pause_to_empty();
		test_random();

		wait_idle();
		$display("%0d ticks sent, %0d result beats checked over %0d cycles", ticks_sent,
			events_seen, cycles);
		$display("forward slides %0d, backward slides %0d, rejected or suppressed %0d, lone pad %0d",
			fwd_slides, bwd_slides, rejected, lone_seen);
		if (errors == 0 && expected_events.size() == 0)
			$display("touch_slide_gesture_detector_top test passed");
		else
			$display("touch_slide_gesture_detector_top test failed");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/tsgd_pkg.sv
rtl/core/tsgd_if.sv
rtl/core/tsgd_div.sv
rtl/core/touch_slide_gesture_detector_top.sv
test/touch_slide_gesture_detector_top_tb.sv
